[hdl/wsfhp_pkg.sv]
// shared types, codes and helpers of the websocket frame header parser
package wsfhp_pkg;

  // depth of the token queue between classifier and assembler
  localparam int QUEUE_DEPTH = 4;

  // token kinds: which header field a byte feeds
  localparam logic [1:0] TK_FIRST  = 2'd0;
  localparam logic [1:0] TK_SECOND = 2'd1;
  localparam logic [1:0] TK_EXTLEN = 2'd2;
  localparam logic [1:0] TK_KEY    = 2'd3;

  // token actions: what the assembler emits after folding the byte in
  localparam logic [1:0] ACT_NONE     = 2'd0;
  localparam logic [1:0] ACT_COMPLETE = 2'd1;
  localparam logic [1:0] ACT_TRUNC    = 2'd2;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // status values of a header result
  localparam logic STATUS_COMPLETE  = 1'b0;
  localparam logic STATUS_TRUNCATED = 1'b1;

  // one classified header byte
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] action;
    logic [7:0] data;
  } tok_t;

  // true when the 7-bit length code calls for extended length bytes
  function automatic logic is_ext_code(input logic [6:0] code);
    is_ext_code = (code == LEN_CODE_16) || (code == LEN_CODE_64);
  endfunction

endpackage

[hdl/wsfhp_if.sv]
// handshake channels of the websocket frame header parser

// header byte channel
interface wsfhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface

// header result channel
interface wsfhp_out_if;
  logic        valid;
  logic        ready;
  logic        final_fragment;
  logic [2:0]  reserved_flags;
  logic [3:0]  opcode;
  logic        masked;
  logic [63:0] payload_length;
  logic [31:0] masking_key;
  logic        status;

  modport source (
    output valid, output final_fragment, output reserved_flags, output opcode,
    output masked, output payload_length, output masking_key, output status,
    input ready
  );
  modport sink (
    input valid, input final_fragment, input reserved_flags, input opcode,
    input masked, input payload_length, input masking_key, input status,
    output ready
  );
endinterface

[hdl/wsfhp_front.sv]
// classifier: tracks the header phase and tags each accepted byte
module wsfhp_front (
  input  logic              clk,
  input  logic              rst_n,
  wsfhp_in_if.sink          in_ch,
  input  logic              q_full,
  output logic              q_push,
  output wsfhp_pkg::tok_t   q_tok
);

  // parse phases
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_EXTLEN = 2'd2;
  localparam logic [1:0] PH_KEY    = 2'd3;

  // byte counts of the variable parts
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] left_r, left_nxt;
  logic       mask_r, mask_nxt;
  logic [3:0] left_dec;
  logic       end_act;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign left_dec    = left_r - 4'd1;

  // truncation on stream end unless the byte completes the header
  assign end_act = in_ch.stream_end;

  // classify the byte and work out the next phase
  always_comb begin
    phase_nxt         = phase_r;
    left_nxt          = left_r;
    mask_nxt          = mask_r;
    q_tok.data        = in_ch.data_byte;
    q_tok.kind        = wsfhp_pkg::TK_FIRST;
    q_tok.action      = end_act ? wsfhp_pkg::ACT_TRUNC : wsfhp_pkg::ACT_NONE;
    unique case (phase_r)
      PH_FIRST: begin
        q_tok.kind = wsfhp_pkg::TK_FIRST;
        phase_nxt  = PH_SECOND;
      end
      PH_SECOND: begin
        q_tok.kind = wsfhp_pkg::TK_SECOND;
        mask_nxt   = in_ch.data_byte[7];
        if (wsfhp_pkg::is_ext_code(in_ch.data_byte[6:0])) begin
          phase_nxt = PH_EXTLEN;
          left_nxt  = (in_ch.data_byte[6:0] == wsfhp_pkg::LEN_CODE_16) ?
                      EXT16_BYTES : EXT64_BYTES;
        end else if (in_ch.data_byte[7]) begin
          phase_nxt = PH_KEY;
          left_nxt  = KEY_BYTES;
        end else begin
          q_tok.action = wsfhp_pkg::ACT_COMPLETE;
        end
      end
      PH_EXTLEN: begin
        q_tok.kind = wsfhp_pkg::TK_EXTLEN;
        left_nxt   = left_dec;
        if (left_dec == 4'd0) begin
          if (mask_r) begin
            phase_nxt = PH_KEY;
            left_nxt  = KEY_BYTES;
          end else begin
            q_tok.action = wsfhp_pkg::ACT_COMPLETE;
          end
        end
      end
      PH_KEY: begin
        q_tok.kind = wsfhp_pkg::TK_KEY;
        left_nxt   = left_dec;
        if (left_dec == 4'd0) begin
          q_tok.action = wsfhp_pkg::ACT_COMPLETE;
        end
      end
      default: begin
        phase_nxt = PH_FIRST;
      end
    endcase
    // any emitted result ends the header
    if (q_tok.action != wsfhp_pkg::ACT_NONE) begin
      phase_nxt = PH_FIRST;
      left_nxt  = 4'd0;
      mask_nxt  = 1'b0;
    end
  end

  // phase registers advance on each byte transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      left_r  <= 4'd0;
      mask_r  <= 1'b0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      mask_r  <= mask_nxt;
    end
  end

endmodule

[hdl/wsfhp_queue.sv]
// small token queue between classifier and assembler
module wsfhp_queue #(
  parameter int DEPTH = wsfhp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wsfhp_pkg::tok_t push_tok,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output wsfhp_pkg::tok_t head_tok
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  wsfhp_pkg::tok_t  slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_tok   = slot_r[rd_ptr_r];

  // storage slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

[hdl/wsfhp_back.sv]
// assembler: folds tagged bytes into header fields and holds the result register
module wsfhp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  wsfhp_pkg::tok_t head_tok,
  output logic            pop,
  wsfhp_out_if.source     out_ch
);

  logic [7:0]  first_r, first_nxt;
  logic        mask_r, mask_nxt;
  logic [63:0] len_r, len_nxt;
  logic [31:0] key_r, key_nxt;
  logic        out_valid_r;
  logic        emits;
  logic        out_free;

  logic        res_fin_r;
  logic [2:0]  res_rsv_r;
  logic [3:0]  res_op_r;
  logic        res_mask_r;
  logic [63:0] res_len_r;
  logic [31:0] res_key_r;
  logic        res_status_r;

  assign emits    = (head_tok.action != wsfhp_pkg::ACT_NONE);
  assign out_free = !out_valid_r || out_ch.ready;
  assign pop      = head_valid && (!emits || out_free);

  // fold the head byte into the header fields
  always_comb begin
    first_nxt = first_r;
    mask_nxt  = mask_r;
    len_nxt   = len_r;
    key_nxt   = key_r;
    unique case (head_tok.kind)
      wsfhp_pkg::TK_FIRST: begin
        first_nxt = head_tok.data;
      end
      wsfhp_pkg::TK_SECOND: begin
        mask_nxt = head_tok.data[7];
        key_nxt  = 32'd0;
        len_nxt  = wsfhp_pkg::is_ext_code(head_tok.data[6:0]) ?
                   64'd0 : {57'd0, head_tok.data[6:0]};
      end
      wsfhp_pkg::TK_EXTLEN: begin
        len_nxt = {len_r[55:0], head_tok.data};
      end
      wsfhp_pkg::TK_KEY: begin
        key_nxt = {key_r[23:0], head_tok.data};
      end
      default: begin
        first_nxt = first_r;
      end
    endcase
  end

  // header field registers
  always_ff @(posedge clk) begin
    if (pop) begin
      first_r <= first_nxt;
      mask_r  <= mask_nxt;
      len_r   <= len_nxt;
      key_r   <= key_nxt;
    end
  end

  // result register load
  always_ff @(posedge clk) begin
    if (pop && emits) begin
      if (head_tok.action == wsfhp_pkg::ACT_COMPLETE) begin
        res_fin_r    <= first_nxt[7];
        res_rsv_r    <= first_nxt[6:4];
        res_op_r     <= first_nxt[3:0];
        res_mask_r   <= mask_nxt;
        res_len_r    <= len_nxt;
        res_key_r    <= mask_nxt ? key_nxt : 32'd0;
        res_status_r <= wsfhp_pkg::STATUS_COMPLETE;
      end else begin
        res_fin_r    <= 1'b0;
        res_rsv_r    <= 3'd0;
        res_op_r     <= 4'd0;
        res_mask_r   <= 1'b0;
        res_len_r    <= 64'd0;
        res_key_r    <= 32'd0;
        res_status_r <= wsfhp_pkg::STATUS_TRUNCATED;
      end
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && emits) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.final_fragment = res_fin_r;
  assign out_ch.reserved_flags = res_rsv_r;
  assign out_ch.opcode         = res_op_r;
  assign out_ch.masked         = res_mask_r;
  assign out_ch.payload_length = res_len_r;
  assign out_ch.masking_key    = res_key_r;
  assign out_ch.status         = res_status_r;

endmodule

[hdl/websocket_frame_header_parser.sv]
// top level of the websocket frame header parser
// Takes one header byte per cycle on in_ch, starting at the first byte of a frame
// header, and delivers one result per header on out_ch: fin, reserved flags,
// opcode, mask bit, the 7-, 16- or 64-bit payload length and the masking key
// (zero when unmasked), with status 0. A byte marked stream_end that does not
// finish a header yields a result with status 1 and all other fields zero, and
// parsing restarts at a new header. Bytes are taken back to back, one per cycle,
// as long as the token queue has room. The last byte of a header passes through
// the token queue and then the result register before out_ch.valid rises, and
// the queue of QUEUE_DEPTH tokens absorbs stalls of out_ch while the result
// register holds.
module websocket_frame_header_parser #(
  parameter int QUEUE_DEPTH = wsfhp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  wsfhp_in_if.sink    in_ch,
  wsfhp_out_if.source out_ch
);

  logic            q_full;
  logic            q_push;
  wsfhp_pkg::tok_t q_tok;
  logic            q_pop;
  logic            q_head_valid;
  wsfhp_pkg::tok_t q_head_tok;

  // byte classifier
  wsfhp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_tok  (q_tok)
  );

  // token queue
  wsfhp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_tok   (q_tok),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_tok   (q_head_tok)
  );

  // field assembler and result register
  wsfhp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_tok   (q_head_tok),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule
